// ----- hdl/bsa_pkg.sv -----
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

  localparam int GROUP_BITS  = 32;
  localparam int GROUP_SHIFT = 5;
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int STATUS_W    = 2;

  localparam logic [COUNT_W-1:0] SLOTS_RESET = 11'd1024;
  localparam logic [GROUP_BITS-1:0] GROUP_ONES = 32'hffffffff;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic clr_write;
    logic accept;
    logic look;
    logic modify;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

// ----- hdl/bsa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bsa_ctrl.sv -----
// Sequencing state machine for the bitmap slot allocator.
module bsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bsa_pkg::stat_t stat,
  output bsa_pkg::cmd_t  cmd,
  output logic          busy
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_MOD   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.modify = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- hdl/bsa_datapath.sv -----
// Free bitmap, group summary, counters and result registers of the allocator.
module bsa_datapath #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bsa_pkg::cmd_t                   cmd,
  output bsa_pkg::stat_t                  stat,
  input  logic                            func,
  input  logic [bsa_pkg::SLOT_W-1:0]      slot_to_free,
  input  logic                            cfg_we,
  input  logic [bsa_pkg::COUNT_W-1:0]     cfg_data,
  output logic                            done,
  output logic [bsa_pkg::SLOT_W-1:0]      granted_slot,
  output logic [bsa_pkg::STATUS_W-1:0]    status,
  output logic [bsa_pkg::COUNT_W-1:0]     allocated_count
);

  localparam int GB         = bsa_pkg::GROUP_BITS;
  localparam int GS         = bsa_pkg::GROUP_SHIFT;
  localparam int NUM_GROUPS = (MAX_SLOTS + GB - 1) / GB;
  localparam int GA_W       = NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1;
  localparam int LIM_W      = $clog2(MAX_SLOTS + 1);
  localparam int LW         = LIM_W > bsa_pkg::COUNT_W ? LIM_W : bsa_pkg::COUNT_W;
  localparam int FG_W       = bsa_pkg::SLOT_W - GS;
  localparam int GX_W       = GA_W > FG_W ? GA_W : FG_W;
  localparam int CW         = LIM_W;
  localparam int OW         = CW > bsa_pkg::COUNT_W ? CW : bsa_pkg::COUNT_W;

  logic [bsa_pkg::COUNT_W-1:0] slots_in_use;
  logic                        req_func;
  logic [bsa_pkg::SLOT_W-1:0]  req_slot;
  logic [NUM_GROUPS-1:0]       summary;
  logic [GA_W-1:0]             clr_addr;
  logic [GA_W-1:0]             look_grp;
  logic                        look_any;
  logic [CW-1:0]               used;
  logic [CW-1:0]               used_next;

  logic [LW-1:0]               su_ext;
  logic [LW-1:0]               limit;
  logic [GA_W-1:0]             first_grp;
  logic                        first_any;
  logic [GX_W-1:0]             free_grp_ext;
  logic [GA_W-1:0]             rd_addr;
  logic [GB-1:0]               rd_data;
  logic [LW-1:0]               base;
  logic [GB-1:0]               valid_mask;
  logic [GB-1:0]               avail;
  logic [GS-1:0]               low_bit;
  logic [GS-1:0]               bit_idx;
  logic [GB-1:0]               bit_onehot;
  logic [LW-1:0]               slot_ext;
  logic [LW-1:0]               grant_ext;
  logic [OW-1:0]               count_ext;
  logic                        bad_free;
  logic                        alloc_ok;
  logic                        map_we;
  logic [GA_W-1:0]             map_waddr;
  logic [GB-1:0]               map_wdata;
  logic [GB-1:0]               new_word;
  logic [bsa_pkg::STATUS_W-1:0] status_next;
  logic [bsa_pkg::SLOT_W-1:0]  granted_next;

  assign su_ext = LW'(slots_in_use);
  assign limit  = (su_ext > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : su_ext;

  always_comb begin
    first_grp = '0;
    first_any = 1'b0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (summary[g]) begin
        first_grp = GA_W'(g);
        first_any = 1'b1;
      end
    end
  end

  assign free_grp_ext = GX_W'(req_slot[bsa_pkg::SLOT_W-1:GS]);
  assign rd_addr      = (req_func == bsa_pkg::FUNC_ALLOC) ? first_grp
                                                           : free_grp_ext[GA_W-1:0];

  bsa_ram #(
    .WIDTH (GB),
    .DEPTH (NUM_GROUPS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (cmd.look),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign base = LW'(look_grp) << GS;

  always_comb begin
    for (int i = 0; i < GB; i++) begin
      valid_mask[i] = ((base | LW'(i)) < limit);
    end
  end

  assign avail = rd_data & valid_mask;

  always_comb begin
    low_bit = '0;
    for (int i = GB - 1; i >= 0; i--) begin
      if (avail[i]) begin
        low_bit = GS'(i);
      end
    end
  end

  assign slot_ext   = LW'(req_slot);
  assign bit_idx    = (req_func == bsa_pkg::FUNC_ALLOC) ? low_bit : req_slot[GS-1:0];
  assign bit_onehot = GB'(1) << bit_idx;
  assign alloc_ok   = look_any && (avail != '0);
  assign bad_free   = (slot_ext >= limit) || (used == '0) || rd_data[req_slot[GS-1:0]];
  assign grant_ext  = LW'({look_grp, low_bit});

  always_comb begin
    new_word     = rd_data;
    used_next    = used;
    status_next  = bsa_pkg::ST_OK;
    granted_next = '0;
    if (req_func == bsa_pkg::FUNC_ALLOC) begin
      if (alloc_ok) begin
        new_word     = rd_data & ~bit_onehot;
        used_next    = used + CW'(1);
        granted_next = grant_ext[bsa_pkg::SLOT_W-1:0];
      end else begin
        status_next = bsa_pkg::ST_FULL;
      end
    end else begin
      if (bad_free) begin
        status_next = bsa_pkg::ST_BAD_FREE;
      end else begin
        new_word  = rd_data | bit_onehot;
        used_next = used - CW'(1);
      end
    end
  end

  assign map_we    = cmd.clr_write ||
                     (cmd.modify && (status_next == bsa_pkg::ST_OK));
  assign map_waddr = cmd.clr_write ? clr_addr : look_grp;
  assign map_wdata = cmd.clr_write ? bsa_pkg::GROUP_ONES : new_word;

  assign stat.clear_last = (clr_addr == GA_W'(NUM_GROUPS - 1));
  assign count_ext       = OW'(used_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= bsa_pkg::SLOTS_RESET;
      summary      <= '1;
      clr_addr     <= '0;
      used         <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_data;
      end
      if (cmd.clr_write) begin
        clr_addr <= clr_addr + GA_W'(1);
      end
      done <= cmd.modify;
      if (cmd.modify) begin
        used <= used_next;
        if (status_next == bsa_pkg::ST_OK) begin
          summary[look_grp] <= (new_word != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_func <= func;
      req_slot <= slot_to_free;
    end
    if (cmd.look) begin
      look_grp <= rd_addr;
      look_any <= (req_func == bsa_pkg::FUNC_ALLOC) ? first_any : 1'b1;
    end
    if (cmd.modify) begin
      granted_slot    <= granted_next;
      status          <= status_next;
      allocated_count <= count_ext[bsa_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ----- hdl/bitmap_slot_allocator_unit.sv -----
// A transaction accepted in idle passes through the look and update states; the result
// strobe is registered from the update state. No new transaction is accepted until the
// look / read / update sequence around the single read and write port of the group
// bitmap RAM ends. Reset: synchronous; afterwards a clearing pass writes every group
// of the bitmap free, one group a cycle, with busy held high.
// Results go out on a one-cycle done strobe; the receiver cannot stall.
module bitmap_slot_allocator_unit #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func,
  input  logic [bsa_pkg::SLOT_W-1:0]   slot_to_free,
  input  logic                         cfg_we,
  input  logic [bsa_pkg::COUNT_W-1:0]  cfg_data,
  output logic                         done,
  output logic [bsa_pkg::SLOT_W-1:0]   granted_slot,
  output logic [bsa_pkg::STATUS_W-1:0] status,
  output logic [bsa_pkg::COUNT_W-1:0]  allocated_count
);

  bsa_pkg::cmd_t  cmd;
  bsa_pkg::stat_t stat;

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (func),
    .slot_to_free    (slot_to_free),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .done            (done),
    .granted_slot    (granted_slot),
    .status          (status),
    .allocated_count (allocated_count)
  );

endmodule

// ----- hdl/bsa_checker.sv -----
// Port-level checks for the bitmap slot allocator, bound to the top level.
module bsa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [bsa_pkg::SLOT_W-1:0]   granted_slot,
  input logic [bsa_pkg::STATUS_W-1:0] status
);

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing three cycles after accepted transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after accepted transaction");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_fail_zero_slot: assert property (@(posedge clk) disable iff (rst)
    (done && (status != bsa_pkg::ST_OK)) |-> (granted_slot == '0))
    else $error("nonzero granted slot on failed transaction");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .granted_slot (granted_slot),
  .status       (status)
);

// ----- tb/bitmap_slot_allocator_unit_tb.sv -----
// Self-checking testbench for the bitmap slot allocator: random and directed requests.
`timescale 1ns / 1ps

module bitmap_slot_allocator_unit_tb;

  localparam int NSLOTS = 1024;

  typedef struct packed {
    logic [NSLOTS-1:0]           free_bits;
    logic [bsa_pkg::COUNT_W-1:0] used;
    logic [bsa_pkg::COUNT_W-1:0] slots_cfg;
  } slot_pool_t;

  typedef struct packed {
    logic [bsa_pkg::SLOT_W-1:0]   slot;
    logic [bsa_pkg::STATUS_W-1:0] st;
    logic [bsa_pkg::COUNT_W-1:0]  count;
  } grant_t;

  typedef struct packed {
    logic                       fn;
    logic [bsa_pkg::SLOT_W-1:0] slot;
  } request_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         func = bsa_pkg::FUNC_ALLOC;
  logic [bsa_pkg::SLOT_W-1:0]   slot_to_free = '0;
  logic                         cfg_we = 1'b0;
  logic [bsa_pkg::COUNT_W-1:0]  cfg_data = '0;
  logic                         done;
  logic [bsa_pkg::SLOT_W-1:0]   granted_slot;
  logic [bsa_pkg::STATUS_W-1:0] status;
  logic [bsa_pkg::COUNT_W-1:0]  allocated_count;

  request_t   request_q[$];
  grant_t     pending_grants[$];
  slot_pool_t chk_pool;
  slot_pool_t gen_pool;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         mismatches = 0;
  int         gap = 0;
  logic       no_gap = 1'b0;

  bitmap_slot_allocator_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .slot_to_free(slot_to_free),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .done(done),
    .granted_slot(granted_slot),
    .status(status),
    .allocated_count(allocated_count)
  );

  always #6 clk = ~clk;

  function automatic int slot_limit(input logic [bsa_pkg::COUNT_W-1:0] cfg);
    return (cfg > NSLOTS) ? NSLOTS : int'(cfg);
  endfunction

  function automatic grant_t apply_request(inout slot_pool_t p, input logic fn,
                                           input logic [bsa_pkg::SLOT_W-1:0] s);
    grant_t r;
    int     lim;
    int     idx;
    lim = slot_limit(p.slots_cfg);
    r.slot = '0;
    r.st = bsa_pkg::ST_OK;
    if (fn == bsa_pkg::FUNC_ALLOC) begin
      r.st = bsa_pkg::ST_FULL;
      idx = -1;
      for (int i = 0; i < lim; i++)
        if (idx < 0 && p.free_bits[i]) idx = i;
      if (idx >= 0) begin
        p.free_bits[idx] = 1'b0;
        p.used = p.used + 1'b1;
        r.slot = idx[bsa_pkg::SLOT_W-1:0];
        r.st = bsa_pkg::ST_OK;
      end
    end else if (int'(s) >= lim || p.used == 0 || p.free_bits[s]) begin
      r.st = bsa_pkg::ST_BAD_FREE;
    end else begin
      p.free_bits[s] = 1'b1;
      p.used = p.used - 1'b1;
    end
    r.count = p.used;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gap || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    request_t req;
    logic     hold;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else begin
      hold = start;
      if (start && !busy) begin
        pending_grants.push_back(apply_request(chk_pool, func, slot_to_free));
        n_accepted++;
        hold = 1'b0;
        if ($urandom_range(49) == 0) no_gap = ~no_gap;
        gap = pick_gap();
      end
      if (!hold) begin
        if (gap > 0) begin
          gap = gap - 1;
          start <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          start <= 1'b1;
          func <= req.fn;
          slot_to_free <= req.slot;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t want;
    if (!rst && done) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result slot=%0d status=%0d count=%0d", $realtime,
                   granted_slot, status, allocated_count);
      end else begin
        want = pending_grants.pop_front();
        if (granted_slot !== want.slot || status !== want.st
            || allocated_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp slot=%0d status=%0d count=%0d, got %0d %0d %0d",
                     $realtime, want.slot, want.st, want.count, granted_slot, status,
                     allocated_count);
        end
      end
    end
  end

  task automatic queue_request(input logic fn, input logic [bsa_pkg::SLOT_W-1:0] s);
    void'(apply_request(gen_pool, fn, s));
    request_q.push_back('{fn: fn, slot: s});
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || pending_grants.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(input logic [bsa_pkg::COUNT_W-1:0] value);
    drain();
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk_pool.slots_cfg = value;
    gen_pool.slots_cfg = value;
  endtask

  task automatic run_phase(input logic [bsa_pkg::COUNT_W-1:0] value, input int n,
                           input int alloc_pct);
    int                         lim;
    logic [bsa_pkg::SLOT_W-1:0] s;
    configure(value);
    lim = slot_limit(value);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < alloc_pct) begin
        queue_request(bsa_pkg::FUNC_ALLOC, bsa_pkg::SLOT_W'($urandom_range(NSLOTS - 1)));
      end else begin
        s = bsa_pkg::SLOT_W'($urandom_range(NSLOTS - 1));
        if (lim > 0 && $urandom_range(4) != 0)
          for (int t = 0; t < 8; t++)
            if (t == 0 || gen_pool.free_bits[s])
              s = bsa_pkg::SLOT_W'($urandom_range(lim - 1));
        queue_request(bsa_pkg::FUNC_FREE, s);
      end
    end
  endtask

  initial begin
    chk_pool.free_bits = '1;
    chk_pool.used = '0;
    chk_pool.slots_cfg = bsa_pkg::SLOTS_RESET;
    gen_pool = chk_pool;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_request(bsa_pkg::FUNC_FREE, 10'd0);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'd0);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'h3ff);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'd0);
    queue_request(bsa_pkg::FUNC_FREE, 10'd1);
    queue_request(bsa_pkg::FUNC_FREE, 10'd1);
    queue_request(bsa_pkg::FUNC_FREE, 10'h3ff);
    queue_request(bsa_pkg::FUNC_FREE, 10'h2aa);
    queue_request(bsa_pkg::FUNC_FREE, 10'h155);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'd0);
    queue_request(bsa_pkg::FUNC_FREE, 10'd0);
    queue_request(bsa_pkg::FUNC_FREE, 10'd2);
    queue_request(bsa_pkg::FUNC_FREE, 10'd1);
    configure(11'd1);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'd0);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'd0);
    queue_request(bsa_pkg::FUNC_FREE, 10'd1);
    queue_request(bsa_pkg::FUNC_FREE, 10'd0);
    queue_request(bsa_pkg::FUNC_FREE, 10'd0);
    configure(11'd0);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'd0);
    queue_request(bsa_pkg::FUNC_FREE, 10'd0);
    queue_request(bsa_pkg::FUNC_ALLOC, 10'h3ff);

    run_phase(11'd2047, 1150, 98);
    run_phase(11'd100, 150, 30);
    run_phase(11'd40, 150, 55);
    run_phase(11'd0, 30, 50);
    run_phase(11'd33, 120, 55);
    run_phase(11'd64, 150, 55);
    run_phase(11'd1024, 120, 50);
    drain();

    if (mismatches == 0 && pending_grants.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/bsa_pkg.sv
hdl/bsa_ram.sv
hdl/bsa_ctrl.sv
hdl/bsa_datapath.sv
hdl/bitmap_slot_allocator_unit.sv
hdl/bsa_checker.sv
tb/bitmap_slot_allocator_unit_tb.sv
